// ----- rtl/plr_pkg.sv -----
`timescale 1ns / 1ps
package plr_pkg;

  localparam int COORD_W   = 32;
  localparam int CHAIN_W   = 48;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int T_W       = 33;
  localparam int DIV_LOW_W = 81;
  localparam int DIV_Q_W   = 33;
  localparam int DIV_CNT_W = 7;
  localparam int SQ_CNT_W  = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_LOC = DIV_CNT_W'(DIV_LOW_W);
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS_T   = DIV_CNT_W'(32);
  localparam logic [SQ_CNT_W-1:0]  SQ_STEPS      = SQ_CNT_W'(ROOT_W);
  localparam logic [T_W-1:0]       T_ONE         = {1'b1, 32'h0};
  localparam logic [CHAIN_W-1:0]   CHAIN_MAX     = '1;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_LOCATE  = 2'd1,
    ACT_NEAREST = 2'd2
  } plr_action_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_LOCATE,
    CMD_NEAREST,
    CMD_NONE
  } plr_cmd_kind_t;

  typedef struct packed {
    logic [1:0]                 action;
    logic                       start_new;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic [CHAIN_W-1:0]         query_chainage;
  } plr_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic [CHAIN_W-1:0]         chainage_out;
    logic [1:0]                 status;
  } plr_out_t;

  typedef struct packed {
    plr_cmd_kind_t              kind;
    logic                       start_new;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic [CHAIN_W-1:0]         qc;
  } plr_cmd_t;

endpackage

// ----- rtl/plr_ram.sv -----
`timescale 1ns / 1ps
module plr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/plr_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. Start remainder must be below divisor.
module plr_div
  import plr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SQ_W-1:0]      rem0,
  input  logic [DIV_LOW_W-1:0] low,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [SQ_W-1:0]      divisor,
  output logic [DIV_Q_W-1:0]   quot,
  output logic                 done
);

  logic                 busy_r;
  logic                 done_r;
  logic [SQ_W-1:0]      rem_r;
  logic [DIV_LOW_W-1:0] low_r;
  logic [SQ_W-1:0]      d_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SQ_W:0]        shifted;
  logic                 take;

  assign shifted = {rem_r, low_r[DIV_LOW_W-1]};
  assign take    = shifted >= {1'b0, d_r};
  assign quot    = q_r;
  assign done    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= rem0;
        low_r  <= low;
        d_r    <= divisor;
        cnt_r  <= steps;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= take ? SQ_W'(shifted - {1'b0, d_r}) : SQ_W'(shifted);
        low_r <= {low_r[DIV_LOW_W-2:0], 1'b0};
        q_r   <= {q_r[DIV_Q_W-2:0], take};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/plr_sqrt.sv -----
`timescale 1ns / 1ps
// Digit-by-digit floor square root, two radicand bits per cycle.
module plr_sqrt
  import plr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int REM_W = ROOT_W + 2;

  logic                busy_r;
  logic                done_r;
  logic [SQ_W-1:0]     rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                take;

  assign rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial  = (REM_W+2)'({root_r, 2'b01});
  assign take   = rem_sh >= trial;
  assign root   = root_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= SQ_STEPS;
      end else if (busy_r) begin
        rem_r  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], take};
        rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == SQ_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/plr_front.sv -----
`timescale 1ns / 1ps
// Accept input transactions, decode the action and queue commands for the back end.
module plr_front
  import plr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  plr_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output plr_cmd_t cmd_data
);

  plr_cmd_t   q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;
  plr_cmd_t   cls;

  always_comb begin
    cls.start_new = in_data.start_new;
    cls.x         = in_data.coord_x;
    cls.y         = in_data.coord_y;
    cls.qc        = in_data.query_chainage;
    unique case (in_data.action)
      ACT_LOAD:    cls.kind = CMD_LOAD;
      ACT_LOCATE:  cls.kind = CMD_LOCATE;
      ACT_NEAREST: cls.kind = CMD_NEAREST;
      default:     cls.kind = CMD_NONE;
    endcase
  end

  assign in_ready  = cnt_r != 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd_data  = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/plr_back.sv -----
`timescale 1ns / 1ps
// Command sequencer: vertex store, shared multiplier, divider and square root.
module plr_back
  import plr_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  plr_cmd_t cmd_data,
  output logic     out_valid,
  input  logic     out_ready,
  output plr_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int RAM_W = 2 * COORD_W + CHAIN_W;

  typedef enum logic [28:0] {
    S_IDLE    = 29'b1 << 0,
    S_LD_SQX  = 29'b1 << 1,
    S_LD_SQY  = 29'b1 << 2,
    S_LD_SUM  = 29'b1 << 3,
    S_LD_ROOT = 29'b1 << 4,
    S_LD_WR   = 29'b1 << 5,
    S_RD      = 29'b1 << 6,
    S_LATCH   = 29'b1 << 7,
    S_LC_MLO  = 29'b1 << 8,
    S_LC_MHI  = 29'b1 << 9,
    S_LC_ADD  = 29'b1 << 10,
    S_LC_DIV  = 29'b1 << 11,
    S_NR_M1   = 29'b1 << 12,
    S_NR_M2   = 29'b1 << 13,
    S_NR_M3   = 29'b1 << 14,
    S_NR_M4   = 29'b1 << 15,
    S_NR_M5   = 29'b1 << 16,
    S_NR_T    = 29'b1 << 17,
    S_NR_DIV  = 29'b1 << 18,
    S_NR_OX   = 29'b1 << 19,
    S_NR_OY   = 29'b1 << 20,
    S_NR_E1   = 29'b1 << 21,
    S_NR_E2   = 29'b1 << 22,
    S_NR_E3   = 29'b1 << 23,
    S_NR_ROOT = 29'b1 << 24,
    S_NR_STEP = 29'b1 << 25,
    S_NR_CAND = 29'b1 << 26,
    S_NR_ADV  = 29'b1 << 27,
    S_OUT     = 29'b1 << 28
  } plr_state_t;

  function automatic logic [MUL_W-1:0] mag34(input logic signed [MUL_W-1:0] v);
    mag34 = v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
  endfunction

  plr_state_t               state_r;
  plr_cmd_t                 cmd_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         i_r;
  logic [CHAIN_W-1:0]       total_r;
  logic signed [COORD_W-1:0] last_x_r, last_y_r;
  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic [CHAIN_W-1:0]       c0_r, c1_r, cq_r, num_r, seg_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, wx_r, wy_r;
  logic signed [MUL_W-1:0]  ex_r, ey_r;
  logic [PROD_W-1:0]        acc_r, best_r, prod_r;
  logic [SQ_W-1:0]          len2_r;
  logic signed [PROD_W-1:0] dot_r;
  logic [T_W-1:0]           t_r;
  logic [ROOT_W-1:0]        len_r;
  logic [DIV_LOW_W-1:0]     pw_r;
  logic                     axis_r, have_r;
  logic signed [COORD_W-1:0] rx_r, ry_r;
  logic [CHAIN_W-1:0]       chain_r;
  logic [1:0]               status_r;
  logic                     out_valid_r;
  plr_out_t                 out_data_r;

  logic [MUL_W-1:0]         mul_a, mul_b;
  logic                     ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [RAM_W-1:0]         ram_rdata;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic [CHAIN_W-1:0]       rd_c;
  logic                     div_start, div_done, sq_start, sq_done;
  logic [SQ_W-1:0]          div_rem0, div_d, sq_rad;
  logic [DIV_LOW_W-1:0]     div_low;
  logic [DIV_CNT_W-1:0]     div_steps;
  logic [DIV_Q_W-1:0]       div_q;
  logic [ROOT_W-1:0]        sq_root;
  logic [CHAIN_W:0]         ld_sum;
  logic [PROD_W-1:0]        d2;
  logic [CHAIN_W:0]         cand;
  logic signed [PROD_W-1:0] p_signed;
  logic [CNT_W-1:0]         i_inc;
  logic signed [COORD_W:0]  a_sel;
  logic signed [COORD_W:0]  interp;

  assign rd_x      = ram_rdata[RAM_W-1 -: COORD_W];
  assign rd_y      = ram_rdata[CHAIN_W +: COORD_W];
  assign rd_c      = ram_rdata[CHAIN_W-1:0];
  assign ram_raddr = i_r[AW-1:0];
  assign ram_we    = state_r == S_LD_WR;
  assign cmd_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign i_inc     = i_r + 1'b1;
  assign ld_sum    = {1'b0, total_r} + (CHAIN_W+1)'(len_r);
  assign d2        = acc_r + prod_r;
  assign cand      = {1'b0, c0_r} + (CHAIN_W+1)'(prod_r[65:32]);
  assign p_signed  = $signed({1'b0, prod_r[PROD_W-2:0]});
  assign a_sel     = axis_r ? {ay_r[COORD_W-1], ay_r} : {ax_r[COORD_W-1], ax_r};
  assign interp    = (axis_r ? dy_r[DIFF_W-1] : dx_r[DIFF_W-1]) ?
                     a_sel - $signed({1'b0, div_q[COORD_W-1:0]}) :
                     a_sel + $signed({1'b0, div_q[COORD_W-1:0]});

  plr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_VERTICES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({cmd_r.x, cmd_r.y, ld_sum[CHAIN_W] ? CHAIN_MAX : ld_sum[CHAIN_W-1:0]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  plr_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .rem0    (div_rem0),
    .low     (div_low),
    .steps   (div_steps),
    .divisor (div_d),
    .quot    (div_q),
    .done    (div_done)
  );

  plr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .root     (sq_root),
    .done     (sq_done)
  );

  // Divider and square-root launches.
  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_low   = pw_r + {prod_r[DIV_LOW_W-33:0], 32'h0};
    div_steps = DIV_STEPS_LOC;
    div_d     = SQ_W'(seg_r);
    sq_start  = 1'b0;
    sq_rad    = len2_r;
    unique case (state_r)
      S_LC_ADD: div_start = 1'b1;
      S_NR_T: begin
        div_rem0  = dot_r[SQ_W-1:0];
        div_low   = '0;
        div_steps = DIV_STEPS_T;
        div_d     = len2_r;
        div_start = len2_r != '0 && !dot_r[PROD_W-1] && dot_r != '0 &&
                    $unsigned(dot_r) < {2'b00, len2_r};
      end
      S_LD_SUM: begin
        sq_rad   = SQ_W'(acc_r + prod_r);
        sq_start = 1'b1;
      end
      S_NR_E3:  sq_start = !have_r || d2 < best_r;
      default: ;
    endcase
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r) inside
      S_LD_SQX, S_NR_M1: begin
        mul_a = mag34({dx_r[DIFF_W-1], dx_r});
        mul_b = mul_a;
      end
      S_LD_SQY, S_NR_M2: begin
        mul_a = mag34({dy_r[DIFF_W-1], dy_r});
        mul_b = mul_a;
      end
      S_LC_MLO: begin
        mul_a = axis_r ? mag34({dy_r[DIFF_W-1], dy_r}) : mag34({dx_r[DIFF_W-1], dx_r});
        mul_b = MUL_W'(num_r[31:0]);
      end
      S_LC_MHI: begin
        mul_a = axis_r ? mag34({dy_r[DIFF_W-1], dy_r}) : mag34({dx_r[DIFF_W-1], dx_r});
        mul_b = MUL_W'(num_r[CHAIN_W-1:32]);
      end
      S_NR_M3: begin
        mul_a = mag34({wx_r[DIFF_W-1], wx_r});
        mul_b = mag34({dx_r[DIFF_W-1], dx_r});
      end
      S_NR_M4: begin
        mul_a = mag34({wy_r[DIFF_W-1], wy_r});
        mul_b = mag34({dy_r[DIFF_W-1], dy_r});
      end
      S_NR_OX: begin
        mul_a = mag34({dx_r[DIFF_W-1], dx_r});
        mul_b = MUL_W'(t_r);
      end
      S_NR_OY: begin
        mul_a = mag34({dy_r[DIFF_W-1], dy_r});
        mul_b = MUL_W'(t_r);
      end
      S_NR_E1: begin
        mul_a = mag34(ex_r);
        mul_b = mul_a;
      end
      S_NR_E2: begin
        mul_a = mag34(ey_r);
        mul_b = mul_a;
      end
      S_NR_STEP: begin
        mul_a = MUL_W'(sq_root);
        mul_b = MUL_W'(t_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT refills the result register itself.
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r    <= cmd_data;
            rx_r     <= '0;
            ry_r     <= '0;
            chain_r  <= '0;
            status_r <= ST_OK;
            have_r   <= 1'b0;
            i_r      <= '0;
            len_r    <= '0;
            cq_r     <= cmd_data.qc < total_r ? cmd_data.qc : total_r;
            dx_r     <= $signed({cmd_data.x[COORD_W-1], cmd_data.x}) -
                        $signed({last_x_r[COORD_W-1], last_x_r});
            dy_r     <= $signed({cmd_data.y[COORD_W-1], cmd_data.y}) -
                        $signed({last_y_r[COORD_W-1], last_y_r});
            unique case (cmd_data.kind)
              CMD_LOAD: begin
                if (cmd_data.start_new) begin
                  // Begin a new line: forget all stored vertices.
                  cnt_r   <= '0;
                  total_r <= '0;
                  state_r <= S_LD_WR;
                end else if (cnt_r == CNT_W'(MAX_VERTICES)) begin
                  status_r <= ST_FULL;
                  chain_r  <= total_r;
                  state_r  <= S_OUT;
                end else if (cnt_r == '0) begin
                  state_r <= S_LD_WR;
                end else begin
                  state_r <= S_LD_SQX;
                end
              end
              CMD_LOCATE:  state_r <= (cnt_r == '0) ? S_OUT : S_RD;
              CMD_NEAREST: state_r <= (cnt_r < CNT_W'(2)) ? S_OUT : S_RD;
              default:     state_r <= S_OUT;
            endcase
          end
        end
        S_LD_SQX: state_r <= S_LD_SQY;
        S_LD_SQY: begin
          acc_r   <= prod_r;
          state_r <= S_LD_SUM;
        end
        S_LD_SUM: state_r <= S_LD_ROOT;
        S_LD_ROOT: begin
          if (sq_done) begin
            len_r   <= sq_root;
            state_r <= S_LD_WR;
          end
        end
        S_LD_WR: begin
          // Store the vertex and its saturated chainage.
          if (ld_sum[CHAIN_W]) begin
            total_r  <= CHAIN_MAX;
            chain_r  <= CHAIN_MAX;
            status_r <= ST_SAT;
          end else begin
            total_r <= ld_sum[CHAIN_W-1:0];
            chain_r <= ld_sum[CHAIN_W-1:0];
          end
          last_x_r <= cmd_r.x;
          last_y_r <= cmd_r.y;
          cnt_r    <= cnt_r + 1'b1;
          state_r  <= S_OUT;
        end
        S_RD: state_r <= S_LATCH;
        S_LATCH: begin
          bx_r <= rd_x;
          by_r <= rd_y;
          c1_r <= rd_c;
          dx_r <= $signed({rd_x[COORD_W-1], rd_x}) - $signed({ax_r[COORD_W-1], ax_r});
          dy_r <= $signed({rd_y[COORD_W-1], rd_y}) - $signed({ay_r[COORD_W-1], ay_r});
          wx_r <= $signed({cmd_r.x[COORD_W-1], cmd_r.x}) - $signed({ax_r[COORD_W-1], ax_r});
          wy_r <= $signed({cmd_r.y[COORD_W-1], cmd_r.y}) - $signed({ay_r[COORD_W-1], ay_r});
          if (i_r == '0) begin
            ax_r <= rd_x;
            ay_r <= rd_y;
            c0_r <= rd_c;
            if (cnt_r == CNT_W'(1)) begin
              rx_r    <= rd_x;
              ry_r    <= rd_y;
              state_r <= S_OUT;
            end else begin
              i_r     <= i_inc;
              state_r <= S_RD;
            end
          end else if (cmd_r.kind == CMD_NEAREST) begin
            state_r <= S_NR_M1;
          end else if (cq_r > rd_c) begin
            // Segment ends before the query: advance.
            ax_r <= rd_x;
            ay_r <= rd_y;
            c0_r <= rd_c;
            i_r  <= i_inc;
            if (i_inc == cnt_r) begin
              rx_r    <= rd_x;
              ry_r    <= rd_y;
              state_r <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end else begin
            seg_r  <= rd_c - c0_r;
            num_r  <= cq_r > c0_r ? cq_r - c0_r : '0;
            axis_r <= 1'b0;
            if (rd_c == c0_r) begin
              rx_r    <= ax_r;
              ry_r    <= ay_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_LC_MLO;
            end
          end
        end
        S_LC_MLO: state_r <= S_LC_MHI;
        S_LC_MHI: begin
          pw_r    <= DIV_LOW_W'(prod_r);
          state_r <= S_LC_ADD;
        end
        S_LC_ADD: state_r <= S_LC_DIV;
        S_LC_DIV: begin
          if (div_done) begin
            if (axis_r) begin
              ry_r    <= interp[COORD_W-1:0];
              state_r <= S_OUT;
            end else begin
              rx_r    <= interp[COORD_W-1:0];
              axis_r  <= 1'b1;
              state_r <= S_LC_MLO;
            end
          end
        end
        S_NR_M1: state_r <= S_NR_M2;
        S_NR_M2: begin
          acc_r   <= prod_r;
          state_r <= S_NR_M3;
        end
        S_NR_M3: begin
          len2_r  <= SQ_W'(acc_r + prod_r);
          state_r <= S_NR_M4;
        end
        S_NR_M4: begin
          dot_r   <= (wx_r[DIFF_W-1] ^ dx_r[DIFF_W-1]) ? -p_signed : p_signed;
          state_r <= S_NR_M5;
        end
        S_NR_M5: begin
          dot_r   <= dot_r + ((wy_r[DIFF_W-1] ^ dy_r[DIFF_W-1]) ? -p_signed : p_signed);
          state_r <= S_NR_T;
        end
        S_NR_T: begin
          // Clamp t to [0, 1]; divide only inside the open interval.
          if (div_start) begin
            state_r <= S_NR_DIV;
          end else begin
            t_r <= (len2_r == '0 || dot_r[PROD_W-1] || dot_r == '0) ? '0 : T_ONE;
            state_r <= S_NR_OX;
          end
        end
        S_NR_DIV: begin
          if (div_done) begin
            t_r     <= {1'b0, div_q[31:0]};
            state_r <= S_NR_OX;
          end
        end
        S_NR_OX: state_r <= S_NR_OY;
        S_NR_OY: begin
          ex_r <= dx_r[DIFF_W-1] ?
                  $signed({wx_r[DIFF_W-1], wx_r}) + $signed({1'b0, prod_r[64:32]}) :
                  $signed({wx_r[DIFF_W-1], wx_r}) - $signed({1'b0, prod_r[64:32]});
          state_r <= S_NR_E1;
        end
        S_NR_E1: begin
          ey_r <= dy_r[DIFF_W-1] ?
                  $signed({wy_r[DIFF_W-1], wy_r}) + $signed({1'b0, prod_r[64:32]}) :
                  $signed({wy_r[DIFF_W-1], wy_r}) - $signed({1'b0, prod_r[64:32]});
          state_r <= S_NR_E2;
        end
        S_NR_E2: begin
          acc_r   <= prod_r;
          state_r <= S_NR_E3;
        end
        S_NR_E3: begin
          // Keep the first strictly closer segment.
          if (sq_start) begin
            best_r  <= d2;
            have_r  <= 1'b1;
            state_r <= S_NR_ROOT;
          end else begin
            state_r <= S_NR_ADV;
          end
        end
        S_NR_ROOT: if (sq_done) state_r <= S_NR_STEP;
        S_NR_STEP: state_r <= S_NR_CAND;
        S_NR_CAND: begin
          if (cand[CHAIN_W]) begin
            chain_r  <= CHAIN_MAX;
            status_r <= ST_SAT;
          end else begin
            chain_r  <= cand[CHAIN_W-1:0];
            status_r <= ST_OK;
          end
          state_r <= S_NR_ADV;
        end
        S_NR_ADV: begin
          ax_r <= bx_r;
          ay_r <= by_r;
          c0_r <= c1_r;
          i_r  <= i_inc;
          state_r <= (i_inc == cnt_r) ? S_OUT : S_RD;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.point_x      <= rx_r;
            out_data_r.point_y      <= ry_r;
            out_data_r.chainage_out <= chain_r;
            out_data_r.status       <= status_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/polyline_linear_referencing_unit.sv -----
`timescale 1ns / 1ps
// Polyline linear referencing unit. Holds one polyline of up to MAX_VERTICES
// vertices (signed Q15.16 coordinates) with the cumulative chainage (unsigned
// Q32.16, saturating) at each vertex. A load transaction appends a vertex and
// returns the new total length; start_new begins a fresh line first; a load
// into a full store is dropped with status 1. A chainage query clamps to
// [0, total] and returns the interpolated point; a nearest query projects the
// point on every segment and returns the chainage of the closest projection.
// Every input transaction yields exactly one result transaction. Items are
// worked one at a time by a sequencer built around one shared 34x34
// multiplier, a one-bit-per-cycle divider and a two-bit-per-cycle square
// root, so latency depends on the action and line length n:
//   load: the first vertex is stored directly, any other waits on the
//     squared differences and the square root of the step length;
//   chainage query: the store is scanned segment by segment, followed
//     by up to two 81-step interpolation divides;
//   nearest query: every segment is scored with the multiplier, plus
//     the projection divide when the projection falls inside the
//     segment and the square root and chainage step when a segment is
//     the new best.
// A two-entry command queue in front and a result register at the output
// let input and output stall independently of the sequencer.
module polyline_linear_referencing_unit
  import plr_pkg::*;
#(
  parameter int MAX_VERTICES = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  plr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output plr_out_t out_data
);

  // Decoded commands travel from the queue to the sequencer.
  logic     cmd_valid;
  logic     cmd_ready;
  plr_cmd_t cmd_data;

  plr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data)
  );

  // Sequencer, vertex store and arithmetic units; owns the result register.
  plr_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
